### hw/rtl/cbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbb_pkg
// Shared types and constants for the cross-shaped box blur.
// ----------------------------------------------------------------------------
package cbb_pkg;

  localparam int HEIGHT_CAP = 4096;
  localparam int ROW_W      = 12;
  localparam int PIX_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;
  localparam logic [3:0]  RADIUS_RST = 4'd1;

  typedef logic [PIX_W-1:0] pix_t;

endpackage

### hw/rtl/cross_box_blur_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cross_box_blur_rgb
// Cross-shaped box blur over a raster stream of 8-bit RGB pixels.
// ----------------------------------------------------------------------------
// Input requests (in_valid/in_stall) carry a pixel (opcode 0) or a drain tick
// (opcode 1). Results leave on out_valid/out_stall; cfg_valid/cfg_ready
// writes width, height or radius and restarts the frame.
// A pixel on row R or below, and a drain tick after the last pixel, yield one
// result: the 2R+1 row and 2R+1 column neighbours are fetched one per cycle
// through the single line-store read port, then three restoring dividers, one
// per channel, divide the sums by 4R+2 in parallel, one quotient bit per cycle.
// The sums are SW bits wide (SW = 14 at MAX_RADIUS 8). in_stall is high while
// a result is being computed or waits for the output register.
// Output is held in a register; if the receiver stalls, the block finishes
// the next result and waits with it until the register is free.
// Reset clears counters, registers take their defaults, no result is pending.
// The line store is not cleared; only entries written in the current frame
// are read.
// ----------------------------------------------------------------------------
module cross_box_blur_rgb #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_opcode,
  input  logic [7:0]                       in_chan0,
  input  logic [7:0]                       in_chan1,
  input  logic [7:0]                       in_chan2,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_chan0,
  output logic [7:0]                       out_chan1,
  output logic [7:0]                       out_chan2,
  output logic                             out_frame_end,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cbb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cbb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int SLOTS = 2 * MAX_RADIUS;
  localparam int SLW   = $clog2(SLOTS);
  localparam int KW    = RW + 2;
  localparam int DW    = RW + 2;
  localparam int SW    = $clog2((4 * MAX_RADIUS + 2) * 255 + 1);
  localparam int DCW   = $clog2(SW + 1);
  localparam int DEPTH = 1 << (SLW + CW);
  localparam int RWD   = cbb_pkg::ROW_W;

  typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_DIV, ST_FIN} state_t;

  state_t state_r;

  logic [10:0]         image_width_r;
  logic [12:0]         image_height_r;
  logic [3:0]          radius_r;

  logic [RWD-1:0]      in_row_r, out_row_r;
  logic [CW-1:0]       in_col_r, out_col_r;
  logic [SLW-1:0]      in_slot_r, out_slot_r;
  logic                in_done_r;

  cbb_pkg::pix_t       pix_r, cen_r, mem_q;
  cbb_pkg::pix_t       mem [0:DEPTH-1];
  logic                ov_r, is_pix_r, fe_r;
  logic                first_r, ph_r, iss_done_r;
  logic signed [KW-1:0] kk_r;
  logic                rd_v_r, rd_oor_r, rd_ov_r, rd_cen_r;
  logic [SW-1:0]       sum_r [3];
  logic [DW-1:0]       rem_r [3];
  logic [DCW-1:0]      dcnt_r;
  logic                out_valid_r, out_fe_r;
  logic [7:0]          out_c_r [3];

  logic [CW-1:0]       w_last;
  logic [RWD-1:0]      h_last;
  logic [RW-1:0]       r_eff;
  logic [DW-1:0]       div_d;
  logic signed [KW-1:0] r_s;
  logic                in_acc, cfg_acc, cfg_hit, emit, out_free;
  logic                in_last, out_last;
  logic signed [15:0]  kk16, cs, ys;
  logic signed [7:0]   ss;
  logic                oor_a, oor_b, f_oor, f_ov;
  logic [RWD-1:0]      f_row;
  logic [CW-1:0]       f_col;
  logic [SLW-1:0]      f_slot;
  logic                mem_we;
  cbb_pkg::pix_t       fval, in_pix;
  logic [DW:0]         dtry [3];
  logic                dge [3];

  function automatic logic [SLW-1:0] slot_inc(input logic [SLW-1:0] s);
    slot_inc = (s == SLW'(SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  always_comb begin
    if (image_width_r == '0) begin
      w_last = '0;
    end else if (32'(image_width_r) > MAX_WIDTH) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(image_width_r - 11'd1);
    end
    if (image_height_r == '0) begin
      h_last = '0;
    end else if (32'(image_height_r) > cbb_pkg::HEIGHT_CAP) begin
      h_last = RWD'(cbb_pkg::HEIGHT_CAP - 1);
    end else begin
      h_last = RWD'(image_height_r - 13'd1);
    end
    if (32'(radius_r) > MAX_RADIUS) begin
      r_eff = RW'(MAX_RADIUS);
    end else begin
      r_eff = RW'(radius_r);
    end
  end

  assign div_d     = {r_eff, 2'b10};
  assign r_s       = $signed({2'b00, r_eff});
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_acc && (cfg_index == cbb_pkg::CFG_WIDTH ||
                     cfg_index == cbb_pkg::CFG_HEIGHT || cfg_index == cbb_pkg::CFG_RADIUS);
  assign emit      = (in_row_r >= RWD'(r_eff));
  assign out_free  = !out_valid_r || !out_stall;
  assign in_last   = (in_row_r == h_last) && (in_col_r == w_last);
  assign out_last  = (out_row_r == h_last) && (out_col_r == w_last);
  assign in_pix    = {in_chan2, in_chan1, in_chan0};

  // neighbour address for the next fetch
  always_comb begin
    kk16  = 16'(kk_r);
    cs    = $signed(16'(out_col_r)) + kk16;
    ys    = $signed(16'(out_row_r)) + kk16;
    oor_a = (cs < 0) || (cs > $signed(16'(w_last)));
    oor_b = (ys < 0) || (ys > $signed(16'(h_last)));
    ss    = $signed(8'(out_slot_r)) + 8'(kk_r);
    if (ss < 0) begin
      ss = ss + 8'(SLOTS);
    end else if (ss >= 8'(SLOTS)) begin
      ss = ss - 8'(SLOTS);
    end
    if (first_r || !ph_r) begin
      f_row  = out_row_r;
      f_slot = out_slot_r;
    end else begin
      f_row  = ys[RWD-1:0];
      f_slot = ss[SLW-1:0];
    end
    if (first_r || ph_r) begin
      f_col = out_col_r;
    end else begin
      f_col = cs[CW-1:0];
    end
    f_oor = !first_r && (ph_r ? oor_b : oor_a);
    f_ov  = ov_r && (f_row == in_row_r) && (f_col == in_col_r);
    fval  = rd_oor_r ? cen_r : (rd_ov_r ? pix_r : mem_q);
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      dtry[l] = {rem_r[l], sum_r[l][SW-1]};
      dge[l]  = (dtry[l] >= {1'b0, div_d});
    end
  end

  assign mem_we = (state_r == ST_IDLE && in_acc && !in_opcode && !in_done_r && !emit) ||
                  (state_r == ST_FIN && out_free && is_pix_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{in_slot_r, in_col_r}] <= (state_r == ST_IDLE) ? in_pix : pix_r;
    end
    mem_q <= mem[{f_slot, f_col}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      image_width_r  <= cbb_pkg::WIDTH_RST;
      image_height_r <= cbb_pkg::HEIGHT_RST;
      radius_r       <= cbb_pkg::RADIUS_RST;
      in_row_r       <= '0;
      in_col_r       <= '0;
      in_slot_r      <= '0;
      out_row_r      <= '0;
      out_col_r      <= '0;
      out_slot_r     <= '0;
      in_done_r      <= 1'b0;
      out_valid_r    <= 1'b0;
      rd_v_r         <= 1'b0;
      iss_done_r     <= 1'b0;
      first_r        <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            pix_r      <= in_pix;
            is_pix_r   <= !in_opcode;
            ov_r       <= !in_opcode;
            fe_r       <= out_last;
            first_r    <= 1'b1;
            ph_r       <= 1'b0;
            iss_done_r <= 1'b0;
            rd_v_r     <= 1'b0;
            kk_r       <= -r_s;
            for (int l = 0; l < 3; l++) begin
              sum_r[l] <= '0;
            end
            if (!in_opcode && !in_done_r) begin
              if (emit) begin
                state_r <= ST_FETCH;
              end else if (in_last) begin
                in_done_r <= 1'b1;
              end else if (in_col_r == w_last) begin
                in_col_r  <= '0;
                in_row_r  <= in_row_r + 1'b1;
                in_slot_r <= slot_inc(in_slot_r);
              end else begin
                in_col_r <= in_col_r + 1'b1;
              end
            end else if (in_opcode && in_done_r) begin
              state_r <= ST_FETCH;
            end
          end
        end
        ST_FETCH: begin
          if (!iss_done_r) begin
            rd_v_r   <= 1'b1;
            rd_oor_r <= f_oor;
            rd_ov_r  <= f_ov;
            rd_cen_r <= first_r;
            if (first_r) begin
              first_r <= 1'b0;
            end else begin
              ph_r <= ~ph_r;
              if (ph_r) begin
                if (kk_r == r_s) begin
                  iss_done_r <= 1'b1;
                end else begin
                  kk_r <= kk_r + 1'b1;
                end
              end
            end
          end else begin
            rd_v_r <= 1'b0;
          end
          if (rd_v_r) begin
            if (rd_cen_r) begin
              cen_r <= fval;
            end else begin
              for (int l = 0; l < 3; l++) begin
                sum_r[l] <= sum_r[l] + SW'(fval[8*l +: 8]);
              end
            end
          end
          if (iss_done_r && !rd_v_r) begin
            for (int l = 0; l < 3; l++) begin
              rem_r[l] <= '0;
            end
            dcnt_r  <= DCW'(SW);
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          for (int l = 0; l < 3; l++) begin
            rem_r[l] <= dge[l] ? DW'(dtry[l] - {1'b0, div_d}) : dtry[l][DW-1:0];
            sum_r[l] <= {sum_r[l][SW-2:0], dge[l]};
          end
          dcnt_r <= dcnt_r - 1'b1;
          if (dcnt_r == DCW'(1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_fe_r    <= fe_r;
            for (int l = 0; l < 3; l++) begin
              out_c_r[l] <= sum_r[l][7:0];
            end
            state_r <= ST_IDLE;
            if (is_pix_r) begin
              if (in_last) begin
                in_done_r <= 1'b1;
              end else if (in_col_r == w_last) begin
                in_col_r  <= '0;
                in_row_r  <= in_row_r + 1'b1;
                in_slot_r <= slot_inc(in_slot_r);
              end else begin
                in_col_r <= in_col_r + 1'b1;
              end
            end
            if (out_last) begin
              in_row_r   <= '0;
              in_col_r   <= '0;
              in_slot_r  <= '0;
              out_row_r  <= '0;
              out_col_r  <= '0;
              out_slot_r <= '0;
              in_done_r  <= 1'b0;
            end else if (out_col_r == w_last) begin
              out_col_r  <= '0;
              out_row_r  <= out_row_r + 1'b1;
              out_slot_r <= slot_inc(out_slot_r);
            end else begin
              out_col_r <= out_col_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (cfg_acc) begin
        case (cfg_index)
          cbb_pkg::CFG_WIDTH:  image_width_r  <= cfg_data[10:0];
          cbb_pkg::CFG_HEIGHT: image_height_r <= cfg_data;
          cbb_pkg::CFG_RADIUS: radius_r       <= cfg_data[3:0];
          default: ;
        endcase
        if (cfg_hit) begin
          in_row_r   <= '0;
          in_col_r   <= '0;
          in_slot_r  <= '0;
          out_row_r  <= '0;
          out_col_r  <= '0;
          out_slot_r <= '0;
          in_done_r  <= 1'b0;
        end
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_chan0     = out_c_r[0];
  assign out_chan1     = out_c_r[1];
  assign out_chan2     = out_c_r[2];
  assign out_frame_end = out_fe_r;

endmodule

### hw/rtl/cbb_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbb_chk
// Port-level checks for the cross-shaped box blur, bound to the top level.
// ----------------------------------------------------------------------------
module cbb_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_chan0,
  input logic       out_frame_end
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_chan0) && $stable(out_frame_end))
    else $error("result changed under stall");

  a_busy_before_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a busy period");

endmodule

bind cross_box_blur_rgb cbb_chk u_cbb_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_chan0     (out_chan0),
  .out_frame_end (out_frame_end)
);

### sim/cbb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbb_checker
// Watches the request, result and register channels of the blur block.
// ----------------------------------------------------------------------------
// Keeps its own line store, raster counters and register copies, predicts the
// blurred pixel for every accepted request that yields a result and compares
// each accepted result against the oldest prediction over all its fields.
// ----------------------------------------------------------------------------
module cbb_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [7:0]                     in_chan0,
  input  logic [7:0]                     in_chan1,
  input  logic [7:0]                     in_chan2,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [7:0]                     out_chan0,
  input  logic [7:0]                     out_chan1,
  input  logic [7:0]                     out_chan2,
  input  logic                           out_frame_end,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [cbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending,
  output logic                           draining
);

  localparam int STORE_W = 1024;
  localparam int SLOTS   = 16;
  localparam int CAP_R   = 8;

  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic       fe;
  } blurred_t;

  cbb_pkg::pix_t line_mem [0:SLOTS*STORE_W-1];
  logic [10:0]   reg_w;
  logic [12:0]   reg_h;
  logic [3:0]    reg_r;
  int            in_row, in_col, out_row, out_col;
  blurred_t      blurred_q [$];

  assign pending = blurred_q.size();

  function automatic int eff_w();
    return (reg_w < 1) ? 1 : (reg_w > STORE_W) ? STORE_W : int'(reg_w);
  endfunction

  function automatic int eff_h();
    return (reg_h < 1) ? 1 : (reg_h > cbb_pkg::HEIGHT_CAP) ? cbb_pkg::HEIGHT_CAP : int'(reg_h);
  endfunction

  function automatic int eff_r();
    return (reg_r > CAP_R) ? CAP_R : int'(reg_r);
  endfunction

  function automatic cbb_pkg::pix_t fetch(int row, int col, bit ov, cbb_pkg::pix_t ov_pix);
    if (ov && row == in_row && col == in_col) return ov_pix;
    return line_mem[(row % SLOTS) * STORE_W + (col % STORE_W)];
  endfunction

  function automatic blurred_t blur_at(int row, int col, bit ov, cbb_pkg::pix_t ov_pix);
    int            w, h, r, c, y;
    int            acc [3];
    cbb_pkg::pix_t ctr, a, b;
    blurred_t      res;
    w = eff_w(); h = eff_h(); r = eff_r();
    ctr = fetch(row, col, ov, ov_pix);
    acc = '{0, 0, 0};
    for (int k = -r; k <= r; k++) begin
      c = col + k;
      y = row + k;
      a = (c < 0 || c >= w) ? ctr : fetch(row, c, ov, ov_pix);
      b = (y < 0 || y >= h) ? ctr : fetch(y, col, ov, ov_pix);
      for (int ch = 0; ch < 3; ch++)
        acc[ch] += int'(a[8*ch +: 8]) + int'(b[8*ch +: 8]);
    end
    res.c0 = 8'(acc[0] / (4 * r + 2));
    res.c1 = 8'(acc[1] / (4 * r + 2));
    res.c2 = 8'(acc[2] / (4 * r + 2));
    res.fe = (row == h - 1 && col == w - 1);
    return res;
  endfunction

  task automatic restart_frame();
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    draining = 1'b0;
  endtask

  task automatic advance_out();
    if (out_row == eff_h() - 1 && out_col == eff_w() - 1) begin
      restart_frame();
    end else if (++out_col >= eff_w()) begin
      out_col = 0;
      out_row++;
    end
  endtask

  task automatic take_request(logic op, cbb_pkg::pix_t pix);
    bit hit;
    hit = 1'b0;
    if (op == cbb_pkg::OP_PIXEL) begin
      if (draining) return;
      if (in_row >= eff_r()) begin
        blurred_q.push_back(blur_at(out_row, out_col, 1'b1, pix));
        hit = 1'b1;
      end
      line_mem[(in_row % SLOTS) * STORE_W + (in_col % STORE_W)] = pix;
      if (in_row == eff_h() - 1 && in_col == eff_w() - 1) begin
        draining = 1'b1;
      end else if (++in_col >= eff_w()) begin
        in_col = 0;
        in_row++;
      end
      if (hit) advance_out();
    end else if (draining) begin
      blurred_q.push_back(blur_at(out_row, out_col, 1'b0, '0));
      advance_out();
    end
  endtask

  task automatic compare_result();
    blurred_t want, got;
    got = '{out_chan0, out_chan1, out_chan2, out_frame_end};
    if (blurred_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result %h %h %h fe=%b", got.c0, got.c1, got.c2, got.fe);
      return;
    end
    want = blurred_q.pop_front();
    if (want != got) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected %h %h %h fe=%b, got %h %h %h fe=%b",
                 want.c0, want.c1, want.c2, want.fe, got.c0, got.c1, got.c2, got.fe);
    end
  endtask

  initial begin
    errors = 0;
    reg_w = cbb_pkg::WIDTH_RST; reg_h = cbb_pkg::HEIGHT_RST; reg_r = cbb_pkg::RADIUS_RST;
    restart_frame();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      reg_w = cbb_pkg::WIDTH_RST; reg_h = cbb_pkg::HEIGHT_RST; reg_r = cbb_pkg::RADIUS_RST;
      restart_frame();
      blurred_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cbb_pkg::CFG_WIDTH: begin
            reg_w = cfg_data[10:0];
            restart_frame();
          end
          cbb_pkg::CFG_HEIGHT: begin
            reg_h = cfg_data[12:0];
            restart_frame();
          end
          cbb_pkg::CFG_RADIUS: begin
            reg_r = cfg_data[3:0];
            restart_frame();
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_request(in_opcode, {in_chan2, in_chan1, in_chan0});
      if (out_valid && !out_stall) compare_result();
    end
  end

endmodule

### sim/tb_cross_box_blur_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cross_box_blur_rgb
// Stimulus and verdict for the cross-shaped box blur.
// ----------------------------------------------------------------------------
// Directed frames cover edge pixels, tiny and maximal sizes, clamped register
// values and the drain corner cases; then random frames with random content,
// broken-off frames and stray requests. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_cross_box_blur_rgb;

  logic                           clk, rst_n;
  logic                           in_valid, in_stall, in_opcode;
  logic [7:0]                     in_chan0, in_chan1, in_chan2;
  logic                           out_valid, out_stall, out_frame_end;
  logic [7:0]                     out_chan0, out_chan1, out_chan2;
  logic                           cfg_valid, cfg_ready;
  logic [cbb_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cbb_pkg::CFG_DATA_W-1:0] cfg_data;
  int                             errors, pending;
  logic                           draining;
  int                             sent;
  bit                             calm, hold_req;
  int                             stall_left;
  int                             cur_w, cur_h;

  cross_box_blur_rgb uut (.*);

  cbb_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 60) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req && stall_left == 0) begin
        stall_left = 400;
        hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        out_stall <= (stall_left > 0);
      end
    end
  end

  task automatic send(logic op, logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_chan0 <= c0; in_chan1 <= c1; in_chan2 <= c2;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_pixel();
    send(cbb_pkg::OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_drain();
    send(cbb_pkg::OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic [cbb_pkg::CFG_IDX_W-1:0] idx, int val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= cbb_pkg::CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == cbb_pkg::CFG_WIDTH)
      cur_w = (val % 2048 < 1) ? 1 : (val % 2048 > 1024) ? 1024 : val % 2048;
    if (idx == cbb_pkg::CFG_HEIGHT)
      cur_h = (val % 8192 < 1) ? 1 : (val % 8192 > 4096) ? 4096 : val % 8192;
  endtask

  task automatic setup(int w, int h, int r);
    write_reg(cbb_pkg::CFG_WIDTH, w);
    write_reg(cbb_pkg::CFG_HEIGHT, h);
    write_reg(cbb_pkg::CFG_RADIUS, r);
  endtask

  // full frame, optionally broken off, then drains with stray requests
  task automatic run_frame(int stop_at);
    int total;
    total = cur_w * cur_h;
    if (stop_at > total) stop_at = total;
    for (int i = 0; i < stop_at; i++) begin
      if ($urandom_range(0, 19) == 0) send_drain();
      send_pixel();
    end
    while (draining) begin
      if ($urandom_range(0, 4) == 0) send_pixel();
      send_drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_opcode = cbb_pkg::OP_PIXEL;
    in_chan0 = '0; in_chan1 = '0; in_chan2 = '0;
    cfg_valid = 1'b0; cfg_index = cbb_pkg::CFG_WIDTH; cfg_data = '0;
    hold_req = 1'b0; calm = 1'b0; sent = 0;
    cur_w = 640; cur_h = 480;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    send(cbb_pkg::OP_DRAIN, 8'hff, 8'hff, 8'hff);
    send(cbb_pkg::OP_PIXEL, 8'h00, 8'hff, 8'h00);
    send(cbb_pkg::OP_PIXEL, 8'hff, 8'h00, 8'hff);

    setup(3, 3, 1);
    send(cbb_pkg::OP_PIXEL, 8'hff, 8'hff, 8'hff);
    send(cbb_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00);
    send(cbb_pkg::OP_PIXEL, 8'hff, 8'h00, 8'hff);
    for (int i = 0; i < 6; i++) send(cbb_pkg::OP_PIXEL, 8'(i * 51), 8'hff, 8'h00);
    send(cbb_pkg::OP_PIXEL, 8'h12, 8'h34, 8'h56);
    while (draining) send(cbb_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);
    send(cbb_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00);

    setup(0, 0, 0);
    send(cbb_pkg::OP_PIXEL, 8'hff, 8'hff, 8'hff);
    setup(2047, 8191, 15);
    for (int i = 0; i < 10; i++) send_pixel();
    setup(1024, 1, 0);
    run_frame(1 << 30);
    setup(1, 20, 8);
    run_frame(1 << 30);

    setup(64, 3, 0);
    hold_req = 1'b1;
    calm = 1'b1;
    run_frame(1 << 30);
    calm = 1'b0;

    while (sent < 1800) begin
      if ($urandom_range(0, 9) == 0)
        setup($urandom_range(0, 2047), $urandom_range(0, 8191), $urandom_range(0, 15));
      else
        setup($urandom_range(1, 16), $urandom_range(1, 12), $urandom_range(0, 8));
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0)
        run_frame($urandom_range(0, (cur_w * cur_h < 300) ? cur_w * cur_h : 300));
      else
        run_frame(300);
      if ($urandom_range(0, 7) == 0) wait_idle();
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/cbb_pkg.sv
hw/rtl/cross_box_blur_rgb.sv
hw/rtl/cbb_chk.sv
sim/cbb_checker.sv
sim/tb_cross_box_blur_rgb.sv
